// ----- src/afrc_pkg.sv -----
// ----------------------------------------------------------------------------
// afrc_pkg
// Shared codes and types for the API frame receive checker.
// ----------------------------------------------------------------------------
package afrc_pkg;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_LEN_HI = 3'd1;
	localparam logic [2:0] PH_LEN_LO = 3'd2;
	localparam logic [2:0] PH_DATA   = 3'd3;
	localparam logic [2:0] PH_CHECK  = 3'd4;

	localparam logic [7:0] START_DELIM = 8'h7E;
	localparam logic [7:0] SUM_BASE    = 8'hFF;

	localparam int ADDR_BYTES = 8;

	typedef struct packed {
		logic        checksum_ok;
		logic [7:0]  frame_type;
		logic [63:0] src_addr;
		logic [15:0] frame_length;
	} res_t;

endpackage

// ----- src/afrc_rx_if.sv -----
// ----------------------------------------------------------------------------
// afrc_rx_if
// Byte channel into the checker: valid/ready with one received byte.
// ----------------------------------------------------------------------------
interface afrc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- src/afrc_res_if.sv -----
// ----------------------------------------------------------------------------
// afrc_res_if
// Result channel out of the checker: valid/ready with one frame verdict.
// ----------------------------------------------------------------------------
interface afrc_res_if;
	logic        valid;
	logic        ready;
	logic        checksum_ok;
	logic [7:0]  frame_type;
	logic [63:0] src_addr;
	logic [15:0] frame_length;

	modport source (output valid, output checksum_ok, output frame_type,
		output src_addr, output frame_length, input ready);
	modport sink (input valid, input checksum_ok, input frame_type,
		input src_addr, input frame_length, output ready);
endinterface

// ----- src/afrc_parse.sv -----
// ----------------------------------------------------------------------------
// afrc_parse
// Frame parser: phase tracking, length capture, running sum, type and
// address capture, and checksum verdict on the final byte.
// ----------------------------------------------------------------------------
module afrc_parse
	import afrc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output logic       emit,
	output res_t       res
);

	logic [2:0]  phase_q;
	logic [15:0] len_q;
	logic [15:0] cnt_q;
	logic [7:0]  sum_q;
	logic [7:0]  type_q;
	logic [63:0] addr_q;

	logic [15:0] cnt_inc;
	logic [63:0] addr_ins;
	logic        ok;

	assign emit    = (phase_q == PH_CHECK);
	assign cnt_inc = cnt_q + 16'd1;
	assign ok      = (rx_byte == (SUM_BASE - sum_q));

	always_comb begin
		addr_ins = addr_q;
		for (int i = 0; i < ADDR_BYTES; i++) begin
			if (cnt_q == 16'(i + 1)) begin
				addr_ins[63 - 8 * i -: 8] = rx_byte;
			end
		end
	end

	always_comb begin
		res.checksum_ok  = ok;
		res.frame_type   = ok ? type_q : 8'd0;
		res.src_addr     = ok ? addr_q : 64'd0;
		res.frame_length = len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			len_q   <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			type_q  <= '0;
			addr_q  <= '0;
		end else if (step) begin
			case (phase_q)
				PH_IDLE: begin
					if (rx_byte == START_DELIM) begin
						len_q   <= '0;
						cnt_q   <= '0;
						sum_q   <= '0;
						type_q  <= '0;
						addr_q  <= '0;
						phase_q <= PH_LEN_HI;
					end
				end
				PH_LEN_HI: begin
					len_q   <= {rx_byte, 8'd0};
					phase_q <= PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_q   <= {len_q[15:8], rx_byte};
					phase_q <= ({len_q[15:8], rx_byte} == 16'd0) ? PH_CHECK : PH_DATA;
				end
				PH_DATA: begin
					sum_q <= sum_q + rx_byte;
					if (cnt_q == 16'd0) begin
						type_q <= rx_byte;
					end
					addr_q <= addr_ins;
					cnt_q  <= cnt_inc;
					if (cnt_inc == len_q) begin
						phase_q <= PH_CHECK;
					end
				end
				PH_CHECK: begin
					phase_q <= PH_IDLE;
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/afrc_out.sv -----
// ----------------------------------------------------------------------------
// afrc_out
// Result register: holds one verdict until the sink takes it.
// ----------------------------------------------------------------------------
module afrc_out
	import afrc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	output logic free,
	afrc_res_if.source res
);

	logic valid_q;
	res_t res_q;

	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res_in;
		end
	end

	assign res.valid        = valid_q;
	assign res.checksum_ok  = res_q.checksum_ok;
	assign res.frame_type   = res_q.frame_type;
	assign res.src_addr     = res_q.src_addr;
	assign res.frame_length = res_q.frame_length;

endmodule

// ----- src/api_frame_receive_checker.sv -----
// ----------------------------------------------------------------------------
// api_frame_receive_checker
// Checks serial API frames with an additive checksum, one byte per item.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle. Bytes land in an input register, the
// parser updates its phase, length, running sum and captured fields from
// that register, and on the checksum byte writes one verdict into the
// result register, so a verdict passes the input and result registers in turn.
// Throughput is one byte every cycle; it drops only while the result
// register is full and a checksum byte waits behind it.
// ----------------------------------------------------------------------------
module api_frame_receive_checker
	import afrc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	afrc_rx_if.sink    rx,
	afrc_res_if.source res
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       step;
	logic       emit;
	logic       out_free;
	res_t       verdict;

	assign step     = valid_s1 && (!emit || out_free);
	assign rx.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	afrc_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.emit    (emit),
		.res     (verdict)
	);

	afrc_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && emit),
		.res_in (verdict),
		.free   (out_free),
		.res    (res)
	);

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |=> res.valid)
		else $error("verdict not presented after checksum byte");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.checksum_ok |->
			res.frame_type == 8'd0 && res.src_addr == 64'd0)
		else $error("rejected frame carries type or address");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(byte_s1))
		else $error("stalled input byte lost");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the API frame receive checker.
// ----------------------------------------------------------------------------
// A queue of received bytes feeds a valid/ready driver, and every byte that
// is taken also updates a frame parser kept in the bench. That parser queues
// the verdict each checksum byte should produce. A monitor compares each
// verdict from the block, field by field, with the oldest one queued.
// Directed frames come first: idle noise, zero length, short and full
// address, a rejected frame, the delimiter used as data, length and checksum,
// and a frame with a non-zero high length byte. Random frames follow. Both
// sides idle at random, and the receiver holds off once for a long stretch
// so the block fills up.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import afrc_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int RANDOM_BYTES   = 400;

	logic clk;
	logic arst_n;

	afrc_rx_if  rx_ch ();
	afrc_res_if res_ch ();

	api_frame_receive_checker DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch.sink),
		.res    (res_ch.source)
	);

	logic [7:0] byte_q[$];
	logic [7:0] body_buf[$];
	res_t       verdict_q[$];

	// frame parser state
	logic [2:0]  frm_phase = PH_IDLE;
	logic [15:0] frm_len   = '0;
	logic [15:0] frm_count = '0;
	logic [7:0]  frm_sum   = '0;
	logic [7:0]  frm_type  = '0;
	logic [63:0] frm_addr  = '0;

	bit tx_gaps_on   = 1'b0;
	bit rx_stalls_on = 1'b0;
	int hold_asked   = 0;
	int hold_given   = 0;
	int send_gap     = 0;
	int rcv_stall    = 0;
	int quiet_cycles = 0;
	int fail_count   = 0;
	int stim_bytes   = 0;

	function automatic int pick_gap(input bit on);
		int r;
		if (!on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		res_t       v;
		logic [7:0] want_ck;
		case (frm_phase)
			PH_IDLE: begin
				if (b == START_DELIM) begin
					frm_len   = '0;
					frm_count = '0;
					frm_sum   = '0;
					frm_type  = '0;
					frm_addr  = '0;
					frm_phase = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				frm_len   = {b, 8'h00};
				frm_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				frm_len[7:0] = b;
				frm_phase    = (frm_len == 16'd0) ? PH_CHECK : PH_DATA;
			end
			PH_DATA: begin
				frm_sum = frm_sum + b;
				if (frm_count == 16'd0)
					frm_type = b;
				else if (int'(frm_count) <= ADDR_BYTES)
					frm_addr[8 * (ADDR_BYTES - int'(frm_count)) +: 8] = b;
				frm_count = frm_count + 16'd1;
				if (frm_count == frm_len)
					frm_phase = PH_CHECK;
			end
			PH_CHECK: begin
				want_ck        = SUM_BASE - frm_sum;
				v.checksum_ok  = (b == want_ck);
				v.frame_type   = v.checksum_ok ? frm_type : 8'h00;
				v.src_addr     = v.checksum_ok ? frm_addr : 64'h0;
				v.frame_length = frm_len;
				verdict_q.push_back(v);
				frm_phase = PH_IDLE;
			end
			default: frm_phase = PH_IDLE;
		endcase
	endfunction

	function automatic bit field_ok(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic check_verdict();
		res_t want;
		bit   ok;
		if (verdict_q.size() == 0) begin
			$display("%0t ns: unexpected verdict, expected none, got ok=%b type=%h addr=%h len=%h",
				$time, res_ch.checksum_ok, res_ch.frame_type, res_ch.src_addr,
				res_ch.frame_length);
			fail_count++;
		end else begin
			want = verdict_q.pop_front();
			ok = field_ok("checksum_ok", 64'(want.checksum_ok), 64'(res_ch.checksum_ok));
			ok &= field_ok("frame_type", 64'(want.frame_type), 64'(res_ch.frame_type));
			ok &= field_ok("src_addr", want.src_addr, res_ch.src_addr);
			ok &= field_ok("frame_length", 64'(want.frame_length), 64'(res_ch.frame_length));
			if (!ok)
				fail_count++;
		end
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid   <= 1'b0;
			rx_ch.rx_byte <= 8'h00;
			send_gap      <= 0;
		end else begin
			if (rx_ch.valid && rx_ch.ready)
				absorb_byte(rx_ch.rx_byte);
			if (!rx_ch.valid || rx_ch.ready) begin
				if (send_gap != 0) begin
					send_gap    <= send_gap - 1;
					rx_ch.valid <= 1'b0;
				end else if (byte_q.size() != 0) begin
					rx_ch.valid   <= 1'b1;
					rx_ch.rx_byte <= byte_q.pop_front();
					send_gap      <= pick_gap(tx_gaps_on);
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// verdict monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			rcv_stall    <= 0;
			hold_given   <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready)
				check_verdict();
			if (hold_given != hold_asked) begin
				hold_given   <= hold_asked;
				rcv_stall    <= HOLD_CYCLES;
				res_ch.ready <= 1'b0;
			end else if (rcv_stall != 0) begin
				rcv_stall    <= rcv_stall - 1;
				res_ch.ready <= 1'b0;
			end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
				rcv_stall    <= pick_gap(1'b1);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (byte_q.size() == 0 && !rx_ch.valid && verdict_q.size() == 0)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic rand_body(input int len);
		body_buf.delete();
		repeat (len)
			body_buf.push_back(($urandom_range(0, 9) == 0) ? START_DELIM : 8'($urandom));
	endtask

	task automatic queue_frame(input bit good);
		logic [7:0]  sum;
		logic [7:0]  cks;
		logic [15:0] len;
		len = 16'(body_buf.size());
		sum = '0;
		foreach (body_buf[i])
			sum = sum + body_buf[i];
		cks = SUM_BASE - sum;
		if (!good)
			cks = cks ^ 8'($urandom_range(1, 255));
		byte_q.push_back(START_DELIM);
		byte_q.push_back(len[15:8]);
		byte_q.push_back(len[7:0]);
		foreach (body_buf[i])
			byte_q.push_back(body_buf[i]);
		byte_q.push_back(cks);
		stim_bytes += body_buf.size() + 4;
	endtask

	task automatic queue_noise(input int n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom);
			if (b == START_DELIM)
				b = b ^ 8'h01;
			byte_q.push_back(b);
		end
	endtask

	function automatic int rand_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 0;
		if (r < 70)
			return $urandom_range(1, 12);
		if (r < 93)
			return $urandom_range(13, 40);
		if (r < 98)
			return $urandom_range(41, 120);
		return $urandom_range(256, 300);
	endfunction

	task automatic queue_random_frame();
		if ($urandom_range(0, 9) == 0)
			queue_noise($urandom_range(1, 5));
		rand_body(rand_len());
		queue_frame($urandom_range(0, 3) != 0);
	endtask

	task automatic queue_random_until(input int goal);
		while (stim_bytes < goal)
			queue_random_frame();
	endtask

	task automatic wait_sent();
		while (byte_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int base;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		@(negedge clk);
		byte_q.push_back(8'h00);
		byte_q.push_back(8'hFF);
		byte_q.push_back(8'h7D);
		byte_q.push_back(8'h7F);
		body_buf.delete();
		queue_frame(1'b1);
		queue_frame(1'b0);
		body_buf = '{8'hFF};
		queue_frame(1'b1);
		// checksum byte equals the delimiter
		body_buf = '{8'h81};
		queue_frame(1'b1);
		body_buf = '{8'h00, 8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hEF};
		queue_frame(1'b1);
		body_buf = '{9{8'hFF}};
		queue_frame(1'b1);
		body_buf = '{9{START_DELIM}};
		queue_frame(1'b1);
		rand_body(5);
		queue_frame(1'b1);
		rand_body(12);
		queue_frame(1'b1);
		rand_body(9);
		queue_frame(1'b0);
		// low length byte equals the delimiter
		rand_body(126);
		queue_frame(1'b1);
		rand_body(1);
		queue_frame(1'b0);
		wait_sent();

		rand_body(260);
		queue_frame(1'b1);
		wait_sent();

		base = stim_bytes;
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		queue_random_until(base + 80);
		wait_sent();

		// long receiver hold while the sender keeps offering
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		hold_asked   = hold_asked + 1;
		queue_random_until(base + 160);
		wait_sent();

		queue_random_until(base + 240);
		wait_sent();

		tx_gaps_on = 1'b1;
		queue_random_until(base + 320);
		wait_sent();

		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b1;
		queue_random_until(base + RANDOM_BYTES);

		while (byte_q.size() != 0 || rx_ch.valid || verdict_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && verdict_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
